[hw/rtl/dsmcc_pkg.sv]
// Shared types, codes and tag tables for the DSM-CC descriptor loop parser.
package dsmcc_pkg;

   localparam int QUEUE_DEPTH = 4;

   // Descriptor kinds
   localparam logic [3:0] KIND_TYPE       = 4'd0;
   localparam logic [3:0] KIND_NAME       = 4'd1;
   localparam logic [3:0] KIND_INFO       = 4'd2;
   localparam logic [3:0] KIND_MODLINK    = 4'd3;
   localparam logic [3:0] KIND_CRC32      = 4'd4;
   localparam logic [3:0] KIND_LOCATION   = 4'd5;
   localparam logic [3:0] KIND_DLTIME     = 4'd6;
   localparam logic [3:0] KIND_GROUPLINK  = 4'd7;
   localparam logic [3:0] KIND_COMPRESSED = 4'd8;
   localparam logic [3:0] KIND_LABEL      = 4'd9;
   localparam logic [3:0] KIND_CACHING    = 4'd10;
   localparam logic [3:0] KIND_CTYPE      = 4'd11;

   // Tag ranges
   localparam logic [7:0] TAG_STD_FIRST  = 8'h01;
   localparam logic [7:0] TAG_STD_LAST   = 8'h09;
   localparam logic [7:0] TAG_PRIV_FIRST = 8'h70;
   localparam logic [7:0] TAG_PRIV_LAST  = 8'h72;

   // Record kinds
   localparam logic [1:0] REC_TEXT  = 2'd0;
   localparam logic [1:0] REC_LANG  = 2'd1;
   localparam logic [1:0] REC_FIXED = 2'd2;
   localparam logic [1:0] REC_EMPTY = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LOOP_END = 2'd1;
   localparam logic [1:0] ERR_SHORT    = 2'd2;

   localparam logic [2:0] LANG_BYTES = 3'd3;

   typedef enum logic [1:0] {
      CLS_TEXT,
      CLS_INFO,
      CLS_FIXED
   } dsmcc_cls_type;

   // One operation handed from the front to the back
   typedef struct packed {
      logic       emit;
      logic       clear;
      logic       small_en;
      logic       wide_en;
      logic       text_en;
      logic       use_acc;
      logic [3:0] kind;
      logic [1:0] record_kind;
      logic [7:0] data;
      logic       desc_last;
      logic [1:0] error;
   } dsmcc_op_type;

   function automatic dsmcc_cls_type kind_class(input logic [3:0] k);
      dsmcc_cls_type c;
      unique case (k) inside
         KIND_TYPE, KIND_NAME, KIND_LABEL, KIND_CTYPE: c = CLS_TEXT;
         KIND_INFO:                                    c = CLS_INFO;
         default:                                      c = CLS_FIXED;
      endcase
      return c;
   endfunction

   // Payload bytes the fields of a kind need
   function automatic logic [2:0] kind_need(input logic [3:0] k);
      logic [2:0] n;
      unique case (k) inside
         KIND_INFO, KIND_MODLINK:          n = 3'd3;
         KIND_CRC32, KIND_DLTIME:          n = 3'd4;
         KIND_LOCATION:                    n = 3'd1;
         KIND_GROUPLINK, KIND_COMPRESSED:  n = 3'd5;
         KIND_CACHING:                     n = 3'd2;
         default:                          n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic kind_has_small(input logic [3:0] k);
      logic h;
      unique case (k) inside
         KIND_MODLINK, KIND_LOCATION, KIND_GROUPLINK, KIND_COMPRESSED, KIND_CACHING: h = 1'b1;
         default: h = 1'b0;
      endcase
      return h;
   endfunction

   // True when payload byte idx belongs to the big-endian wide field
   function automatic logic kind_in_wide(input logic [3:0] k, input logic [2:0] idx);
      logic w;
      unique case (k) inside
         KIND_MODLINK:                    w = (idx >= 3'd1) && (idx <= 3'd2);
         KIND_CRC32, KIND_DLTIME:         w = (idx <= 3'd3);
         KIND_GROUPLINK, KIND_COMPRESSED: w = (idx >= 3'd1) && (idx <= 3'd4);
         KIND_CACHING:                    w = (idx == 3'd1);
         default:                         w = 1'b0;
      endcase
      return w;
   endfunction

   function automatic logic tag_known(input logic [7:0] tag);
      return ((tag >= TAG_STD_FIRST) && (tag <= TAG_STD_LAST)) ||
             ((tag >= TAG_PRIV_FIRST) && (tag <= TAG_PRIV_LAST));
   endfunction

   function automatic logic [3:0] tag_kind(input logic [7:0] tag);
      logic [7:0] d;
      logic [3:0] k;
      if ((tag >= TAG_STD_FIRST) && (tag <= TAG_STD_LAST)) begin
         d = tag - TAG_STD_FIRST;
         k = d[3:0];
      end else if ((tag >= TAG_PRIV_FIRST) && (tag <= TAG_PRIV_LAST)) begin
         d = tag - TAG_PRIV_FIRST;
         k = d[3:0] + KIND_LABEL;
      end else begin
         k = KIND_TYPE;
      end
      return k;
   endfunction

endpackage

[hw/rtl/dsmcc_descriptor_tlv_parser.sv]
// Top level of the DSM-CC descriptor loop parser: front end, operation queue, back end.
// A taken byte request's operation passes through the queue, then into the back-end result register on rsp_.
// Throughput: one byte request per cycle while the queue is not full, set by the framing update in the
// front end and one queue pop per cycle in the back end while its result register is not stalled.
// Reset (synchronous, active high) returns the parser to expecting a tag byte, empties
// the queue, clears the field accumulators and drops any pending result.
module dsmcc_descriptor_tlv_parser #(
   parameter int QUEUE_DEPTH = dsmcc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // byte requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_loop_end,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [1:0]  rsp_record_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [7:0]  rsp_small_value,
   output logic [31:0] rsp_wide_value,
   output logic        rsp_desc_last,
   output logic [1:0]  rsp_error
);

   // Front-to-back operation path
   dsmcc_pkg::dsmcc_op_type push_op;
   dsmcc_pkg::dsmcc_op_type head_op;
   logic push;
   logic pop;
   logic q_full;
   logic q_empty;

   // Front end: tag/length/payload framing; stalls requests only when the queue is full
   dsmcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .req_loop_end(req_loop_end),
      .q_full      (q_full),
      .q_push      (push),
      .q_op        (push_op)
   );

   // Queue: decouples framing from a stalled result consumer
   dsmcc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .push_op(push_op),
      .pop    (pop),
      .head_op(head_op),
      .full   (q_full),
      .empty  (q_empty)
   );

   // Back end: accumulate big-endian fields, hold the result until taken.
   // Operations that emit nothing drain even while the result register is stalled.
   dsmcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_op        (head_op),
      .q_empty        (q_empty),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_record_kind(rsp_record_kind),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_small_value(rsp_small_value),
      .rsp_wide_value (rsp_wide_value),
      .rsp_desc_last  (rsp_desc_last),
      .rsp_error      (rsp_error)
   );

endmodule

[hw/rtl/dsmcc_front.sv]
// Front end: tracks descriptor framing and turns each byte into a back-end operation.
module dsmcc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_byte_in,
   input  logic                  req_loop_end,
   input  logic                  q_full,
   output logic                  q_push,
   output dsmcc_pkg::dsmcc_op_type q_op
);

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_PAY
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] kind_ff, kind_in;
   logic       known_ff, known_in;
   logic [7:0] left_ff, left_in;
   logic [2:0] idx_ff, idx_in;

   dsmcc_pkg::dsmcc_op_type op;
   dsmcc_pkg::dsmcc_cls_type cls;
   logic       accept;
   logic       lastb;
   logic [3:0] idx_next;
   logic       short_pay;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cls       = dsmcc_pkg::kind_class(kind_ff);
   assign lastb     = (left_ff == 8'd1);
   assign idx_next  = {1'b0, idx_ff} + 4'd1;
   assign short_pay = idx_next < {1'b0, dsmcc_pkg::kind_need(kind_ff)};

   always_comb begin
      op          = '0;
      op.data     = req_byte_in;
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      known_in    = known_ff;
      left_in     = left_ff;
      idx_in      = idx_ff;
      unique case (phase_ff)
         PH_LEN: begin
            left_in = req_byte_in;
            idx_in  = '0;
            if (req_byte_in == 8'd0) begin
               phase_in = PH_TAG;
               if (known_ff) begin
                  op.emit      = 1'b1;
                  op.kind      = kind_ff;
                  op.desc_last = 1'b1;
                  unique case (cls)
                     dsmcc_pkg::CLS_TEXT: begin
                        op.record_kind = dsmcc_pkg::REC_EMPTY;
                     end
                     dsmcc_pkg::CLS_INFO: begin
                        op.record_kind = dsmcc_pkg::REC_EMPTY;
                        op.error       = dsmcc_pkg::ERR_SHORT;
                     end
                     default: begin
                        op.record_kind = dsmcc_pkg::REC_FIXED;
                        op.use_acc     = 1'b1;
                        op.error       = dsmcc_pkg::ERR_SHORT;
                     end
                  endcase
               end
            end else begin
               phase_in = PH_PAY;
            end
         end
         PH_PAY: begin
            left_in = left_ff - 8'd1;
            if (idx_ff != 3'd7) begin
               idx_in = idx_ff + 3'd1;
            end
            if (lastb) begin
               phase_in = PH_TAG;
            end
            if (known_ff) begin
               op.kind = kind_ff;
               unique case (cls)
                  dsmcc_pkg::CLS_TEXT: begin
                     op.emit        = 1'b1;
                     op.text_en     = 1'b1;
                     op.record_kind = dsmcc_pkg::REC_TEXT;
                     op.desc_last   = lastb;
                  end
                  dsmcc_pkg::CLS_INFO: begin
                     op.emit        = 1'b1;
                     op.text_en     = 1'b1;
                     op.record_kind = (idx_ff < dsmcc_pkg::LANG_BYTES) ?
                                      dsmcc_pkg::REC_LANG : dsmcc_pkg::REC_TEXT;
                     op.desc_last   = lastb;
                     if (lastb && short_pay) begin
                        op.error = dsmcc_pkg::ERR_SHORT;
                     end
                  end
                  default: begin
                     op.small_en = (idx_ff == 3'd0) && dsmcc_pkg::kind_has_small(kind_ff);
                     op.wide_en  = dsmcc_pkg::kind_in_wide(kind_ff, idx_ff);
                     if (lastb) begin
                        op.emit        = 1'b1;
                        op.use_acc     = 1'b1;
                        op.record_kind = dsmcc_pkg::REC_FIXED;
                        op.desc_last   = 1'b1;
                        if (short_pay) begin
                           op.error = dsmcc_pkg::ERR_SHORT;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            // Tag byte: classify and clear the field accumulators
            known_in = dsmcc_pkg::tag_known(req_byte_in);
            kind_in  = dsmcc_pkg::tag_kind(req_byte_in);
            left_in  = '0;
            idx_in   = '0;
            op.clear = 1'b1;
            phase_in = PH_LEN;
         end
      endcase

      // Loop ends inside a descriptor: close it out with an error
      if (req_loop_end && (phase_in != PH_TAG)) begin
         if (!op.emit) begin
            op.emit = 1'b1;
            if (known_in) begin
               op.kind = kind_in;
               if (dsmcc_pkg::kind_class(kind_in) == dsmcc_pkg::CLS_FIXED) begin
                  op.record_kind = dsmcc_pkg::REC_FIXED;
                  op.use_acc     = 1'b1;
               end else begin
                  op.record_kind = dsmcc_pkg::REC_EMPTY;
               end
            end
         end
         op.desc_last = 1'b1;
         op.error     = dsmcc_pkg::ERR_LOOP_END;
         phase_in     = PH_TAG;
      end
   end

   assign q_op   = op;
   assign q_push = accept && (op.emit || op.clear || op.small_en || op.wide_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         kind_ff  <= '0;
         known_ff <= 1'b0;
         left_ff  <= '0;
         idx_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         known_ff <= known_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[hw/rtl/dsmcc_queue.sv]
// Short operation queue between the parser front end and the field back end.
module dsmcc_queue #(
   parameter int DEPTH = dsmcc_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dsmcc_pkg::dsmcc_op_type push_op,
   input  logic                    pop,
   output dsmcc_pkg::dsmcc_op_type head_op,
   output logic                    full,
   output logic                    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsmcc_pkg::dsmcc_op_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/dsmcc_back.sv]
// Back end: collects fixed fields and holds the outgoing result register.
module dsmcc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  dsmcc_pkg::dsmcc_op_type head_op,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [3:0]              rsp_kind,
   output logic [1:0]              rsp_record_kind,
   output logic [7:0]              rsp_text_byte,
   output logic [7:0]              rsp_small_value,
   output logic [31:0]             rsp_wide_value,
   output logic                    rsp_desc_last,
   output logic [1:0]              rsp_error
);

   logic [7:0]  small_acc_ff, small_acc_in;
   logic [31:0] wide_acc_ff, wide_acc_in;
   logic        valid_ff;
   logic [3:0]  kind_ff;
   logic [1:0]  rec_ff;
   logic [7:0]  text_ff;
   logic [7:0]  small_ff;
   logic [31:0] wide_ff;
   logic        last_ff;
   logic [1:0]  error_ff;
   logic        out_free;
   logic        load;
   logic [7:0]  small_base;
   logic [31:0] wide_base;

   assign out_free = !valid_ff || !rsp_stall;
   assign q_pop    = !q_empty && (!head_op.emit || out_free);
   assign load     = q_pop && head_op.emit;

   always_comb begin
      small_base   = head_op.clear ? '0 : small_acc_ff;
      wide_base    = head_op.clear ? '0 : wide_acc_ff;
      small_acc_in = head_op.small_en ? head_op.data : small_base;
      wide_acc_in  = head_op.wide_en ? {wide_base[23:0], head_op.data} : wide_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_acc_ff <= '0;
         wide_acc_ff  <= '0;
      end else if (q_pop) begin
         small_acc_ff <= small_acc_in;
         wide_acc_ff  <= wide_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head_op.kind;
         rec_ff   <= head_op.record_kind;
         text_ff  <= head_op.text_en ? head_op.data : '0;
         small_ff <= head_op.use_acc ? small_acc_in : '0;
         wide_ff  <= head_op.use_acc ? wide_acc_in : '0;
         last_ff  <= head_op.desc_last;
         error_ff <= head_op.error;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_record_kind = rec_ff;
   assign rsp_text_byte   = text_ff;
   assign rsp_small_value = small_ff;
   assign rsp_wide_value  = wide_ff;
   assign rsp_desc_last   = last_ff;
   assign rsp_error       = error_ff;

endmodule

[hw/rtl/dsmcc_checker.sv]
// Port-level checks for the DSM-CC descriptor loop parser, bound to the top level.
module dsmcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_byte_in,
   input logic        req_loop_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_kind,
   input logic [1:0]  rsp_record_kind,
   input logic [7:0]  rsp_text_byte,
   input logic [7:0]  rsp_small_value,
   input logic [31:0] rsp_wide_value,
   input logic        rsp_desc_last,
   input logic [1:0]  rsp_error
);

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_record_kind) && $stable(rsp_text_byte) && $stable(rsp_small_value) &&
      $stable(rsp_wide_value) && $stable(rsp_desc_last) && $stable(rsp_error))
      else $error("stalled result changed");

   // A loop-end error always closes the descriptor
   a_loop_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error == dsmcc_pkg::ERR_LOOP_END) |-> rsp_desc_last)
      else $error("loop-end error without descriptor end");

   // Records and empty-text results end the descriptor and carry no text byte
   a_record_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_record_kind == dsmcc_pkg::REC_FIXED) ||
                    (rsp_record_kind == dsmcc_pkg::REC_EMPTY))
      |-> rsp_desc_last && (rsp_text_byte == 8'd0))
      else $error("malformed record result");

   // Text results never carry field values
   a_text_no_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_record_kind == dsmcc_pkg::REC_TEXT) ||
                    (rsp_record_kind == dsmcc_pkg::REC_LANG))
      |-> (rsp_small_value == 8'd0) && (rsp_wide_value == 32'd0))
      else $error("text result with field values");

endmodule

bind dsmcc_descriptor_tlv_parser dsmcc_checker u_dsmcc_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the DSM-CC descriptor loop parser.
`timescale 1ns / 100ps

module testbench;

   // Hold the watchdog this many cycles with no request or result taken. At 73 percent
   // idling on either side, a real stall this long does not happen.
   localparam int unsigned QUIET_LIMIT = 2000;
   // Extra cycles to wait after every expected result is in, before the next phase.
   localparam int unsigned SETTLE_CYCLES = 6;

   typedef enum logic [1:0] {
      EXPECT_TAG,
      EXPECT_LEN,
      IN_PAYLOAD
   } parse_phase_type;

   // How one kind lays out its payload.
   typedef struct {
      dsmcc_pkg::dsmcc_cls_type cls;
      int                       need;
      bit                       has_small;
      int                       wide_first;
      int                       wide_last;
   } kind_layout_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [1:0]  record_kind;
      logic [7:0]  text_byte;
      logic [7:0]  small_value;
      logic [31:0] wide_value;
      logic        desc_last;
      logic [1:0]  error;
   } desc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_loop_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [1:0]  rsp_record_kind;
   logic [7:0]  rsp_text_byte;
   logic [7:0]  rsp_small_value;
   logic [31:0] rsp_wide_value;
   logic        rsp_desc_last;
   logic [1:0]  rsp_error;

   // Predicted parser state
   parse_phase_type parse_phase = EXPECT_TAG;
   logic [3:0]      cur_kind = 4'd0;
   logic            tag_is_known = 1'b0;
   logic [7:0]      bytes_left = 8'd0;
   logic [7:0]      payload_index = 8'd0;
   logic [7:0]      small_acc = 8'd0;
   logic [31:0]     wide_acc = 32'd0;

   desc_result_type pending_results[$];
   desc_result_type oldest;
   int unsigned     mismatches = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     send_idle_pct = 24;
   int unsigned     rsp_idle_pct = 73;

   dsmcc_descriptor_tlv_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .req_loop_end    (req_loop_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_record_kind (rsp_record_kind),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_small_value (rsp_small_value),
      .rsp_wide_value  (rsp_wide_value),
      .rsp_desc_last   (rsp_desc_last),
      .rsp_error       (rsp_error)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Field layout per kind. Kinds with no wide field get an empty byte range.
   function automatic kind_layout_type layout_of(input logic [3:0] k);
      kind_layout_type lay;
      lay = '{dsmcc_pkg::CLS_FIXED, 0, 1'b0, 1, 0};
      case (k) inside
         dsmcc_pkg::KIND_TYPE, dsmcc_pkg::KIND_NAME, dsmcc_pkg::KIND_LABEL,
         dsmcc_pkg::KIND_CTYPE: lay.cls = dsmcc_pkg::CLS_TEXT;
         dsmcc_pkg::KIND_INFO: begin
            lay.cls = dsmcc_pkg::CLS_INFO;
            lay.need = 3;
         end
         dsmcc_pkg::KIND_MODLINK:    lay = '{dsmcc_pkg::CLS_FIXED, 3, 1'b1, 1, 2};
         dsmcc_pkg::KIND_CRC32:      lay = '{dsmcc_pkg::CLS_FIXED, 4, 1'b0, 0, 3};
         dsmcc_pkg::KIND_LOCATION:   lay = '{dsmcc_pkg::CLS_FIXED, 1, 1'b1, 1, 0};
         dsmcc_pkg::KIND_DLTIME:     lay = '{dsmcc_pkg::CLS_FIXED, 4, 1'b0, 0, 3};
         dsmcc_pkg::KIND_GROUPLINK:  lay = '{dsmcc_pkg::CLS_FIXED, 5, 1'b1, 1, 4};
         dsmcc_pkg::KIND_COMPRESSED: lay = '{dsmcc_pkg::CLS_FIXED, 5, 1'b1, 1, 4};
         dsmcc_pkg::KIND_CACHING:    lay = '{dsmcc_pkg::CLS_FIXED, 2, 1'b1, 1, 1};
         default:                    lay.cls = dsmcc_pkg::CLS_TEXT;
      endcase
      return lay;
   endfunction

   // Advance the predicted parser by one byte and queue the result it causes, if any.
   function automatic void parse_byte(input logic [7:0] b, input logic last_of_loop);
      kind_layout_type lay;
      desc_result_type r;
      bit              have;
      logic [7:0]      idx;
      bit              final_byte;
      r = '0;
      have = 1'b0;
      lay = layout_of(cur_kind);
      case (parse_phase)
         EXPECT_LEN: begin
            bytes_left = b;
            payload_index = 8'd0;
            if (b == 8'd0) begin
               // Empty payload: text gives an empty record, info and fixed kinds are short
               if (tag_is_known) begin
                  have = 1'b1;
                  r.kind = cur_kind;
                  r.desc_last = 1'b1;
                  if (lay.cls == dsmcc_pkg::CLS_TEXT) begin
                     r.record_kind = dsmcc_pkg::REC_EMPTY;
                  end else if (lay.cls == dsmcc_pkg::CLS_INFO) begin
                     r.record_kind = dsmcc_pkg::REC_EMPTY;
                     r.error = dsmcc_pkg::ERR_SHORT;
                  end else begin
                     r.record_kind = dsmcc_pkg::REC_FIXED;
                     r.error = dsmcc_pkg::ERR_SHORT;
                  end
               end
               parse_phase = EXPECT_TAG;
            end else begin
               parse_phase = IN_PAYLOAD;
            end
         end
         IN_PAYLOAD: begin
            idx = payload_index;
            bytes_left = bytes_left - 8'd1;
            final_byte = (bytes_left == 8'd0);
            if (tag_is_known) begin
               if (lay.cls == dsmcc_pkg::CLS_TEXT) begin
                  have = 1'b1;
                  r.kind = cur_kind;
                  r.record_kind = dsmcc_pkg::REC_TEXT;
                  r.text_byte = b;
                  r.desc_last = final_byte;
               end else if (lay.cls == dsmcc_pkg::CLS_INFO) begin
                  // The first three bytes carry the language code
                  have = 1'b1;
                  r.kind = cur_kind;
                  r.record_kind = (idx < 8'd3) ? dsmcc_pkg::REC_LANG : dsmcc_pkg::REC_TEXT;
                  r.text_byte = b;
                  r.desc_last = final_byte;
                  if (final_byte && (int'(idx) + 1 < lay.need)) r.error = dsmcc_pkg::ERR_SHORT;
               end else begin
                  // Collect big-endian fields; drop surplus bytes
                  if (idx == 8'd0 && lay.has_small) small_acc = b;
                  if (int'(idx) >= lay.wide_first && int'(idx) <= lay.wide_last) begin
                     wide_acc = {wide_acc[23:0], b};
                  end
                  if (final_byte) begin
                     have = 1'b1;
                     r.kind = cur_kind;
                     r.record_kind = dsmcc_pkg::REC_FIXED;
                     r.small_value = small_acc;
                     r.wide_value = wide_acc;
                     r.desc_last = 1'b1;
                     if (int'(idx) + 1 < lay.need) r.error = dsmcc_pkg::ERR_SHORT;
                  end
               end
            end
            if (payload_index != 8'hFF) payload_index = payload_index + 8'd1;
            if (final_byte) parse_phase = EXPECT_TAG;
         end
         default: begin
            // Tag byte: classify and clear the field accumulators
            if (b >= dsmcc_pkg::TAG_STD_FIRST && b <= dsmcc_pkg::TAG_STD_LAST) begin
               tag_is_known = 1'b1;
               cur_kind = 4'(b - dsmcc_pkg::TAG_STD_FIRST);
            end else if (b >= dsmcc_pkg::TAG_PRIV_FIRST && b <= dsmcc_pkg::TAG_PRIV_LAST) begin
               tag_is_known = 1'b1;
               cur_kind = 4'(b - dsmcc_pkg::TAG_PRIV_FIRST) + dsmcc_pkg::KIND_LABEL;
            end else begin
               tag_is_known = 1'b0;
               cur_kind = dsmcc_pkg::KIND_TYPE;
            end
            lay = layout_of(cur_kind);
            bytes_left = 8'd0;
            payload_index = 8'd0;
            small_acc = 8'd0;
            wide_acc = 32'd0;
            parse_phase = EXPECT_LEN;
         end
      endcase

      // Loop ended inside a descriptor: flag the result of this byte, or make one up
      if (last_of_loop && parse_phase != EXPECT_TAG) begin
         if (!have) begin
            have = 1'b1;
            if (tag_is_known) begin
               r.kind = cur_kind;
               if (lay.cls == dsmcc_pkg::CLS_FIXED) begin
                  r.record_kind = dsmcc_pkg::REC_FIXED;
                  r.small_value = small_acc;
                  r.wide_value = wide_acc;
               end else begin
                  r.record_kind = dsmcc_pkg::REC_EMPTY;
               end
            end
         end
         r.desc_last = 1'b1;
         r.error = dsmcc_pkg::ERR_LOOP_END;
         parse_phase = EXPECT_TAG;
      end
      if (have) pending_results.push_back(r);
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   // Randomize the receiver's stall each cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Predict on every request taken, then check every result taken against the oldest
   // prediction. Reset the quiet counter on any handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) parse_byte(req_byte_in, req_loop_end);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with nothing expected: kind %0d record_kind %0d",
                      rsp_kind, rsp_record_kind);
               mismatches++;
            end else begin
               oldest = pending_results.pop_front();
               check_field("kind", 32'(oldest.kind), 32'(rsp_kind));
               check_field("record_kind", 32'(oldest.record_kind), 32'(rsp_record_kind));
               check_field("text_byte", 32'(oldest.text_byte), 32'(rsp_text_byte));
               check_field("small_value", 32'(oldest.small_value), 32'(rsp_small_value));
               check_field("wide_value", oldest.wide_value, rsp_wide_value);
               check_field("desc_last", 32'(oldest.desc_last), 32'(rsp_desc_last));
               check_field("error", 32'(oldest.error), 32'(rsp_error));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // End the run when nothing moves for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("testbench failed");
      $finish;
   end

   // Send one byte request: idle at random first, then hold it until taken.
   task automatic send_byte(input logic [7:0] b, input logic last_of_loop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_loop_end <= last_of_loop;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Send tag, length and up to eight payload bytes taken from the top of pay.
   task automatic send_desc(input logic [7:0] tag, input int unsigned len,
                            input logic [63:0] pay);
      int unsigned i;
      send_byte(tag, 1'b0);
      send_byte(8'(len), 1'b0);
      for (i = 0; i < len; i++) send_byte(pay[63 - 8 * i -: 8], 1'b0);
   endtask

   // Hold off the sender until every expected result is in, then retune idling.
   task automatic drain_results(input int unsigned next_send_idle,
                                input int unsigned next_rsp_idle);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      send_idle_pct = next_send_idle;
      rsp_idle_pct = next_rsp_idle;
      @(posedge clock);
   endtask

   task automatic test_empty_payloads;
      send_desc(8'h01, 0, 64'h0);
      send_desc(8'h03, 0, 64'h0);
      send_desc(8'h05, 0, 64'h0);
   endtask

   task automatic test_content_type;
      send_desc(8'h72, 1, 64'hFF00_0000_0000_0000);
   endtask

   task automatic test_short_info;
      send_desc(8'h03, 2, 64'h656E_0000_0000_0000);
   endtask

   // All-ones crc, then caching with one surplus byte.
   task automatic test_fixed_fields;
      send_desc(8'h05, 4, 64'hFFFF_FFFF_0000_0000);
      send_desc(8'h71, 3, 64'h8012_3400_0000_0000);
   endtask

   task automatic test_unknown_tag;
      send_desc(8'h00, 1, 64'h5A00_0000_0000_0000);
   endtask

   // Drop the loop mid-descriptor: an unknown tag on its length byte, then modlink
   // after its position byte.
   task automatic test_loop_end;
      send_byte(8'hFF, 1'b0);
      send_byte(8'h02, 1'b1);
      send_byte(8'h04, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h11, 1'b1);
   endtask

   // Mostly well-formed loops of known tags with random payloads; some loops cut short,
   // some bursts of noise that always end the loop so that parsing resyncs.
   task automatic test_random_loops(input int unsigned byte_goal);
      logic [7:0]  loop_bytes[$];
      logic [7:0]  tag;
      int unsigned start_count, n_desc, n_noise, last_start, cut, len, pick, d, i;
      start_count = bytes_sent;
      while (bytes_sent - start_count < byte_goal) begin
         if ($urandom_range(99) < 6) begin
            n_noise = $urandom_range(1, 4);
            for (i = 0; i < n_noise; i++) send_byte(8'($urandom_range(255)), i == n_noise - 1);
         end else begin
            loop_bytes.delete();
            last_start = 0;
            n_desc = $urandom_range(1, 3);
            for (d = 0; d < n_desc; d++) begin
               last_start = loop_bytes.size();
               if ($urandom_range(99) < 85) begin
                  pick = $urandom_range(11);
                  tag = (pick < 9) ? 8'(pick + 1) : 8'(dsmcc_pkg::TAG_PRIV_FIRST + pick - 9);
               end else begin
                  tag = 8'($urandom_range(255));
               end
               // Keep most payloads short; longer ones reach past the fixed fields
               pick = $urandom_range(99);
               if (pick < 70) len = $urandom_range(0, 8);
               else if (pick < 95) len = $urandom_range(9, 24);
               else len = $urandom_range(25, 60);
               loop_bytes.push_back(tag);
               loop_bytes.push_back(8'(len));
               repeat (len) loop_bytes.push_back(8'($urandom_range(255)));
            end
            cut = loop_bytes.size() - 1;
            if ($urandom_range(99) < 15) cut = $urandom_range(last_start, cut);
            for (i = 0; i <= cut; i++) send_byte(loop_bytes[i], i == cut);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_payloads;
      test_content_type;
      test_short_info;
      test_fixed_fields;
      test_unknown_tag;
      test_loop_end;
      test_random_loops(160);
      drain_results(73, 24);
      test_random_loops(160);
      drain_results(0, 0);
      test_random_loops(160);
      drain_results(0, 0);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
